### design/hdtx_pkg.sv
// hdtx_pkg: shared types and constants of the half-duplex transmit sequencer
// used by hdtx_ctrl, hdtx_dp and halfduplex_tx_sequencer_top
`timescale 1ns / 1ps

package hdtx_pkg;

    // field widths fixed by the interface
    localparam int WORD_W    = 16;
    localparam int BYTE_W    = 8;
    localparam int LEVEL_W   = 5;
    localparam int PHASE_W   = 3;
    localparam int TICK_W    = 4;
    localparam int BUSY_W    = 16;
    localparam int CODE_W    = 4;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;

    // parameter defaults
    localparam int DEF_RING_DEPTH = 256;
    localparam int DEF_FIFO_BYTES = 16;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BOARD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LEAD  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_DRAIN = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_LIMIT = 2'd3;

    // configuration reset values
    localparam logic [CODE_W-1:0] RST_BOARD = 4'd4;
    localparam logic [TICK_W-1:0] RST_LEAD  = 4'd2;
    localparam logic [TICK_W-1:0] RST_DRAIN = 4'd3;
    localparam logic [BUSY_W-1:0] RST_LIMIT = 16'd1000;

    // board codes with special release timing
    localparam logic [CODE_W-1:0] BOARD_IMMEDIATE = 4'd4;
    localparam logic [CODE_W-1:0] BOARD_ONE_TICK  = 4'd5;

    localparam logic [TICK_W-1:0] TICK_MAX = 4'd15;

    // input operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POLL = 1'b1;

    // result kinds
    localparam logic KIND_STATUS = 1'b0;
    localparam logic KIND_BYTE   = 1'b1;

    typedef enum logic [PHASE_W-1:0] {
        PH_IDLE    = 3'd0,
        PH_LEAD    = 3'd1,
        PH_SEND    = 3'd2,
        PH_DRAIN   = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EVAL,
        ST_FETCH,
        ST_LO,
        ST_HI,
        ST_STATUS
    } ctrl_state_t;

    // controller to datapath
    typedef struct packed {
        logic load_item;
        logic eval;
        logic rd_issue;
        logic load_lo;
        logic load_hi;
        logic load_status;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic out_free;
        logic xfer_none;
        logic words_done;
    } stat_t;

endpackage

### design/hdtx_ctrl.sv
// hdtx_ctrl: control state machine of the transmit sequencer
// depends on hdtx_pkg; drives hdtx_dp through cmd_t, watches stat_t
`timescale 1ns / 1ps

module hdtx_ctrl
    import hdtx_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    ctrl_state_t state_reg, state_next;

    // state register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) state_next = ST_EVAL;
            end
            ST_EVAL: begin
                state_next = stat.xfer_none ? ST_STATUS : ST_FETCH;
            end
            ST_FETCH: begin
                state_next = ST_LO;
            end
            ST_LO: begin
                if (stat.out_free) state_next = ST_HI;
            end
            ST_HI: begin
                if (stat.out_free) state_next = stat.words_done ? ST_STATUS : ST_LO;
            end
            ST_STATUS: begin
                if (stat.out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // command outputs
    always_comb begin
        s_ready = 1'b0;
        cmd     = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready       = 1'b1;
                cmd.load_item = s_valid;
            end
            ST_EVAL: begin
                cmd.eval = 1'b1;
            end
            ST_FETCH: begin
                cmd.rd_issue = 1'b1;
            end
            ST_LO: begin
                cmd.load_lo = stat.out_free;
            end
            ST_HI: begin
                cmd.load_hi  = stat.out_free;
                cmd.rd_issue = stat.out_free & ~stat.words_done;
            end
            ST_STATUS: begin
                cmd.load_status = stat.out_free;
            end
            default: begin
                s_ready = 1'b0;
            end
        endcase
    end

endmodule

### design/hdtx_dp.sv
// hdtx_dp: word ring, sequencer state, configuration and result register
// depends on hdtx_pkg; commanded by hdtx_ctrl
`timescale 1ns / 1ps

module hdtx_dp
    import hdtx_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int FIFO_BYTES = DEF_FIFO_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  cmd_t                 cmd,
    output stat_t                stat,
    input  logic                 s_op,
    input  logic [WORD_W-1:0]    s_word,
    input  logic                 s_tick,
    input  logic                 s_fifo_int,
    input  logic [LEVEL_W-1:0]   s_fifo_level,
    input  logic                 s_line_busy,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic [BYTE_W-1:0]    m_tx_byte,
    output logic                 m_tx_enable,
    output logic [PHASE_W-1:0]   m_phase,
    output logic                 m_int_clear,
    output logic                 m_last
);

    localparam int IDX_W = $clog2(RING_DEPTH);
    localparam int SP_W  = $clog2(FIFO_BYTES + 1);
    localparam int CNT_W = $clog2(FIFO_BYTES / 2 + 1);
    localparam int LW    = LEVEL_W + SP_W;
    localparam int CW    = IDX_W + SP_W + 1;

    // ring advance with wrap at the depth
    function automatic logic [IDX_W-1:0] idx_add(input logic [IDX_W-1:0] a,
                                                 input logic [CNT_W-1:0] n);
        logic [IDX_W:0] s;
        s = {1'b0, a} + (IDX_W+1)'(n);
        if (s >= (IDX_W+1)'(RING_DEPTH)) s = s - (IDX_W+1)'(RING_DEPTH);
        return s[IDX_W-1:0];
    endfunction

    // words moved by one transfer: min(pending, free space / 2), or zero when en is low
    function automatic logic [CNT_W-1:0] xfer_count(input logic en,
                                                    input logic [IDX_W-1:0] lim,
                                                    input logic [IDX_W-1:0] rd,
                                                    input logic [LEVEL_W-1:0] lvl);
        logic [IDX_W-1:0] pend;
        logic [LW-1:0]    lvl_x;
        logic [LW-1:0]    space_x;
        logic [CW-1:0]    pend_x;
        logic [CW-1:0]    half_x;
        logic [CW-1:0]    n_x;
        lvl_x = LW'(lvl);
        if (lvl_x > LW'(FIFO_BYTES)) space_x = '0;
        else space_x = LW'(FIFO_BYTES) - lvl_x;
        half_x = CW'(space_x >> 1);
        if (lim >= rd) pend = lim - rd;
        else pend = IDX_W'((IDX_W+1)'(lim) + (IDX_W+1)'(RING_DEPTH) - (IDX_W+1)'(rd));
        pend_x = CW'(pend);
        n_x = (pend_x < half_x) ? pend_x : half_x;
        if (!en) n_x = '0;
        return CNT_W'(n_x);
    endfunction

    // latched input word
    logic                op_reg;
    logic [WORD_W-1:0]   word_reg;
    logic                tick_reg;
    logic                fifo_int_reg;
    logic [LEVEL_W-1:0]  level_reg;
    logic                line_busy_reg;

    // configuration
    logic [CODE_W-1:0]   board_reg;
    logic [TICK_W-1:0]   lead_reg;
    logic [TICK_W-1:0]   drain_reg;
    logic [BUSY_W-1:0]   limit_reg;

    // sequencer state
    logic [IDX_W-1:0]    read_idx_reg, read_idx_next;
    logic [IDX_W-1:0]    write_idx_reg, write_idx_next;
    logic [IDX_W-1:0]    end_idx_reg, end_idx_next;
    phase_t              phase_reg, phase_next;
    logic [TICK_W-1:0]   tick_cnt_reg, tick_cnt_next;
    logic [BUSY_W-1:0]   busy_cnt_reg, busy_cnt_next;
    logic                driver_reg, driver_next;
    logic                clear_reg, clear_next;

    // byte fetch
    logic [IDX_W-1:0]    fetch_ptr_reg;
    logic [CNT_W-1:0]    words_left_reg, words_left_next;
    logic [WORD_W-1:0]   rdata_reg;
    logic [WORD_W-1:0]   ring_mem [RING_DEPTH];

    // result register
    logic                m_valid_reg;
    logic                m_kind_reg;
    logic [BYTE_W-1:0]   m_byte_reg;
    logic                m_enable_reg;
    logic [PHASE_W-1:0]  m_phase_reg;
    logic                m_clear_reg;
    logic                m_last_reg;

    logic [IDX_W-1:0]    write_inc;
    logic                ring_full;
    logic                ring_wr;
    logic [CNT_W-1:0]    n_send;
    logic [CNT_W-1:0]    n_drain;
    logic [IDX_W-1:0]    rd_after_send;
    logic [IDX_W-1:0]    rd_after_drain;
    logic                moved;

    // push side
    assign write_inc = idx_add(write_idx_reg, CNT_W'(1));
    assign ring_full = (write_inc == read_idx_reg);
    assign ring_wr   = cmd.eval & (op_reg == OP_PUSH) & ~ring_full;

    // the two possible transfers of a poll
    assign n_send         = xfer_count(fifo_int_reg, write_idx_reg, read_idx_reg, level_reg);
    assign n_drain        = xfer_count(fifo_int_reg, end_idx_reg, read_idx_reg, level_reg);
    assign rd_after_send  = idx_add(read_idx_reg, n_send);
    assign rd_after_drain = idx_add(read_idx_reg, n_drain);

    // phase update of one item
    always_comb begin
        read_idx_next   = read_idx_reg;
        write_idx_next  = write_idx_reg;
        end_idx_next    = end_idx_reg;
        phase_next      = phase_reg;
        tick_cnt_next   = tick_cnt_reg;
        busy_cnt_next   = busy_cnt_reg;
        driver_next     = driver_reg;
        clear_next      = 1'b0;
        words_left_next = '0;
        moved           = 1'b0;
        if (op_reg == OP_PUSH) begin
            if (!ring_full) write_idx_next = write_inc;
        end else begin
            // tick accounting and busy timeout
            if (tick_reg) begin
                if (phase_next == PH_IDLE) begin
                    busy_cnt_next = '0;
                end else if (busy_cnt_next < limit_reg) begin
                    busy_cnt_next = busy_cnt_next + BUSY_W'(1);
                end else begin
                    busy_cnt_next = '0;
                    phase_next    = PH_IDLE;
                    driver_next   = 1'b0;
                end
                if (tick_cnt_next < TICK_MAX) tick_cnt_next = tick_cnt_next + TICK_W'(1);
            end
            // start when data waits and the line is not busy
            if (phase_next == PH_IDLE && read_idx_reg != write_idx_reg && !line_busy_reg) begin
                driver_next   = 1'b1;
                phase_next    = PH_LEAD;
                tick_cnt_next = '0;
            end
            // lead-in
            if (phase_next == PH_LEAD) begin
                if (board_reg == BOARD_IMMEDIATE && line_busy_reg) begin
                    driver_next = 1'b0;
                    phase_next  = PH_IDLE;
                end else if (tick_cnt_next >= lead_reg && !line_busy_reg) begin
                    tick_cnt_next = '0;
                    phase_next    = PH_SEND;
                end
            end
            // send
            if (phase_next == PH_SEND) begin
                if (read_idx_reg != write_idx_reg) begin
                    moved           = 1'b1;
                    clear_next      = fifo_int_reg;
                    words_left_next = n_send;
                    read_idx_next   = rd_after_send;
                end
                if (tick_cnt_next > drain_reg) begin
                    end_idx_next  = write_idx_reg;
                    phase_next    = PH_DRAIN;
                    tick_cnt_next = '0;
                end
            end
            // drain
            if (phase_next == PH_DRAIN) begin
                if (read_idx_next != end_idx_next) begin
                    if (!moved) begin
                        clear_next      = fifo_int_reg;
                        words_left_next = n_drain;
                        read_idx_next   = rd_after_drain;
                    end
                end else begin
                    driver_next   = 1'b0;
                    phase_next    = PH_RELEASE;
                    tick_cnt_next = '0;
                end
            end
            // release
            if (phase_next == PH_RELEASE) begin
                if (board_reg == BOARD_IMMEDIATE ||
                    (board_reg == BOARD_ONE_TICK && tick_cnt_next >= TICK_W'(1))) begin
                    phase_next    = PH_IDLE;
                    tick_cnt_next = '0;
                end
            end
        end
    end

    // input word latch
    always_ff @(posedge aclk) begin
        if (cmd.load_item) begin
            op_reg        <= s_op;
            word_reg      <= s_word;
            tick_reg      <= s_tick;
            fifo_int_reg  <= s_fifo_int;
            level_reg     <= s_fifo_level;
            line_busy_reg <= s_line_busy;
        end
    end

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            board_reg <= RST_BOARD;
            lead_reg  <= RST_LEAD;
            drain_reg <= RST_DRAIN;
            limit_reg <= RST_LIMIT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                CFG_BOARD: board_reg <= cfg_data[CODE_W-1:0];
                CFG_LEAD:  lead_reg  <= cfg_data[TICK_W-1:0];
                CFG_DRAIN: drain_reg <= cfg_data[TICK_W-1:0];
                CFG_LIMIT: limit_reg <= cfg_data[BUSY_W-1:0];
                default:   board_reg <= board_reg;
            endcase
        end
    end

    // sequencer state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            read_idx_reg   <= '0;
            write_idx_reg  <= '0;
            end_idx_reg    <= '0;
            phase_reg      <= PH_IDLE;
            tick_cnt_reg   <= '0;
            busy_cnt_reg   <= '0;
            driver_reg     <= 1'b0;
            clear_reg      <= 1'b0;
            words_left_reg <= '0;
            fetch_ptr_reg  <= '0;
        end else if (cmd.eval) begin
            read_idx_reg   <= read_idx_next;
            write_idx_reg  <= write_idx_next;
            end_idx_reg    <= end_idx_next;
            phase_reg      <= phase_next;
            tick_cnt_reg   <= tick_cnt_next;
            busy_cnt_reg   <= busy_cnt_next;
            driver_reg     <= driver_next;
            clear_reg      <= clear_next;
            words_left_reg <= words_left_next;
            fetch_ptr_reg  <= read_idx_reg;
        end else if (cmd.rd_issue) begin
            words_left_reg <= words_left_reg - CNT_W'(1);
            fetch_ptr_reg  <= idx_add(fetch_ptr_reg, CNT_W'(1));
        end
    end

    // word ring, one write and one registered read port
    always_ff @(posedge aclk) begin
        if (ring_wr) ring_mem[write_idx_reg] <= word_reg;
        if (cmd.rd_issue) rdata_reg <= ring_mem[fetch_ptr_reg];
    end

    // result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_lo || cmd.load_hi || cmd.load_status) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge aclk) begin
        if (cmd.load_lo || cmd.load_hi || cmd.load_status) begin
            m_enable_reg <= driver_reg;
            m_phase_reg  <= phase_reg;
            m_kind_reg   <= cmd.load_status ? KIND_STATUS : KIND_BYTE;
            m_clear_reg  <= cmd.load_status & clear_reg;
            m_last_reg   <= cmd.load_status;
            if (cmd.load_lo) m_byte_reg <= rdata_reg[BYTE_W-1:0];
            else if (cmd.load_hi) m_byte_reg <= rdata_reg[WORD_W-1:BYTE_W];
            else m_byte_reg <= '0;
        end
    end

    assign stat.out_free   = ~m_valid_reg | m_ready;
    assign stat.xfer_none  = (words_left_next == '0);
    assign stat.words_done = (words_left_reg == '0);

    assign m_valid     = m_valid_reg;
    assign m_kind      = m_kind_reg;
    assign m_tx_byte   = m_byte_reg;
    assign m_tx_enable = m_enable_reg;
    assign m_phase     = m_phase_reg;
    assign m_int_clear = m_clear_reg;
    assign m_last      = m_last_reg;

endmodule

### design/halfduplex_tx_sequencer_top.sv
// Timing: one item at a time. A push, or a poll that moves no word, is evaluated and gives
// its status word; the next item is taken once that word is loaded. A poll moving words
// gives the low, then the high byte of each before its status word: one ring read per word
// and, while the result side is ready, one byte per cycle through the result register.
// Reset: synchronous active-low aresetn clears indexes, phase, counters, driver enable and
// the configuration registers to their defaults; the ring contents are not cleared.
`timescale 1ns / 1ps

module halfduplex_tx_sequencer_top
    import hdtx_pkg::*;
#(
    parameter int RING_DEPTH = DEF_RING_DEPTH,
    parameter int FIFO_BYTES = DEF_FIFO_BYTES
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_op,
    input  logic [WORD_W-1:0]    s_word,
    input  logic                 s_tick,
    input  logic                 s_fifo_int,
    input  logic [LEVEL_W-1:0]   s_fifo_level,
    input  logic                 s_line_busy,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_DAT_W-1:0] cfg_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_kind,
    output logic [BYTE_W-1:0]    m_tx_byte,
    output logic                 m_tx_enable,
    output logic [PHASE_W-1:0]   m_phase,
    output logic                 m_int_clear,
    output logic                 m_last
);

    cmd_t  cmd;
    stat_t stat;

    // configuration writes are always taken
    assign cfg_ready = 1'b1;

    hdtx_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    hdtx_dp #(
        .RING_DEPTH (RING_DEPTH),
        .FIFO_BYTES (FIFO_BYTES)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cmd          (cmd),
        .stat         (stat),
        .s_op         (s_op),
        .s_word       (s_word),
        .s_tick       (s_tick),
        .s_fifo_int   (s_fifo_int),
        .s_fifo_level (s_fifo_level),
        .s_line_busy  (s_line_busy),
        .cfg_valid    (cfg_valid),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_tx_byte    (m_tx_byte),
        .m_tx_enable  (m_tx_enable),
        .m_phase      (m_phase),
        .m_int_clear  (m_int_clear),
        .m_last       (m_last)
    );

`ifndef SYNTHESIS
    // one item in flight: input side closes right after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> !s_ready)
        else $error("input accepted while an item is in flight");

    // byte words never carry the interrupt clear or the final mark
    a_byte_word: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_kind == KIND_BYTE) |-> (!m_int_clear && !m_last))
        else $error("byte word with status flags");

    // driver enable is on exactly in lead, send and drain
    a_enable_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_tx_enable == (m_phase == PH_LEAD || m_phase == PH_SEND ||
                                     m_phase == PH_DRAIN)))
        else $error("driver enable does not match phase");
`endif

endmodule

### dv/tb_top.sv
// tb_top: self-checking testbench for halfduplex_tx_sequencer_top
// depends on hdtx_pkg and the design sources; predicts every result word in-line
`timescale 1ns / 1ps

module tb_top;
    import hdtx_pkg::*;

    localparam int IDX_W       = $clog2(DEF_RING_DEPTH);
    localparam int CYCLE_LIMIT = 400000;
    localparam int PRINT_CAP   = 100;

    typedef struct packed {
        logic               kind;
        logic [BYTE_W-1:0]  tx_byte;
        logic               tx_enable;
        logic [PHASE_W-1:0] phase;
        logic               int_clear;
        logic               last;
    } uart_out_t;

    // clock, reset and block inputs, all known from time zero
    logic                 aclk         = 1'b0;
    logic                 aresetn      = 1'b0;
    logic                 s_valid      = 1'b0;
    logic                 s_op         = OP_PUSH;
    logic [WORD_W-1:0]    s_word       = '0;
    logic                 s_tick       = 1'b0;
    logic                 s_fifo_int   = 1'b0;
    logic [LEVEL_W-1:0]   s_fifo_level = '0;
    logic                 s_line_busy  = 1'b0;
    logic                 cfg_valid    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index    = CFG_BOARD;
    logic [CFG_DAT_W-1:0] cfg_data     = '0;
    logic                 m_ready      = 1'b0;

    logic                 s_ready;
    logic                 cfg_ready;
    logic                 m_valid;
    logic                 m_kind;
    logic [BYTE_W-1:0]    m_tx_byte;
    logic                 m_tx_enable;
    logic [PHASE_W-1:0]   m_phase;
    logic                 m_int_clear;
    logic                 m_last;

    // predicted sequencer state
    logic [WORD_W-1:0] ring_copy [DEF_RING_DEPTH];
    logic [IDX_W-1:0]  rd_idx   = '0;
    logic [IDX_W-1:0]  wr_idx   = '0;
    logic [IDX_W-1:0]  end_idx  = '0;
    phase_t            ph       = PH_IDLE;
    logic [TICK_W-1:0] tick_cnt = '0;
    logic [BUSY_W-1:0] busy_cnt = '0;
    logic              drv      = 1'b0;

    // predicted configuration
    logic [CODE_W-1:0] cur_board = RST_BOARD;
    logic [TICK_W-1:0] cur_lead  = RST_LEAD;
    logic [TICK_W-1:0] cur_drain = RST_DRAIN;
    logic [BUSY_W-1:0] cur_limit = RST_LIMIT;

    uart_out_t         uart_due [$];
    logic [BYTE_W-1:0] burst_bytes [$];
    logic              burst_clear;
    uart_out_t         want_now;

    int   errors      = 0;
    int   cycles      = 0;
    int   rx_hold     = 0;
    int   rx_wait     = 0;
    logic src_gaps    = 1'b1;
    logic sink_stalls = 1'b1;

    halfduplex_tx_sequencer_top dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_word       (s_word),
        .s_tick       (s_tick),
        .s_fifo_int   (s_fifo_int),
        .s_fifo_level (s_fifo_level),
        .s_line_busy  (s_line_busy),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_kind       (m_kind),
        .m_tx_byte    (m_tx_byte),
        .m_tx_enable  (m_tx_enable),
        .m_phase      (m_phase),
        .m_int_clear  (m_int_clear),
        .m_last       (m_last)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // watchdog
    always @(posedge aclk) begin
        cycles = cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d words still due", cycles, uart_due.size());
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        if (errors < PRINT_CAP)
            $display("mismatch %s: got %0h want %0h at cycle %0d", what, got, want, cycles);
        errors = errors + 1;
    endtask

    // move up to free/2 ring words into the burst, low byte first
    task automatic move_words(input logic fint, input logic [LEVEL_W-1:0] level,
                              input logic [IDX_W-1:0] limit);
        logic [IDX_W-1:0] pending;
        int room;
        int n;
        if (!fint)
            return;
        pending = limit - rd_idx;
        if (pending == 0)
            return;
        room = (int'(level) > DEF_FIFO_BYTES) ? 0 : DEF_FIFO_BYTES - int'(level);
        room = room / 2;
        n = (int'(pending) < room) ? int'(pending) : room;
        repeat (n) begin
            burst_bytes.push_back(ring_copy[rd_idx][7:0]);
            burst_bytes.push_back(ring_copy[rd_idx][15:8]);
            rd_idx = rd_idx + 1'b1;
        end
        burst_clear = 1'b1;
    endtask

    // advance the predicted sequencer by one accepted word and queue its results
    task automatic run_sequencer(input logic op, input logic [WORD_W-1:0] word,
                                 input logic tick, input logic fint,
                                 input logic [LEVEL_W-1:0] level, input logic busy);
        logic [IDX_W-1:0] nxt;
        logic moved;
        uart_out_t item;
        moved = 1'b0;
        burst_clear = 1'b0;
        burst_bytes.delete();
        if (op == OP_PUSH) begin
            // a push into a full ring is dropped
            nxt = wr_idx + 1'b1;
            if (nxt != rd_idx) begin
                ring_copy[wr_idx] = word;
                wr_idx = nxt;
            end
        end else begin
            // busy timeout and saturating tick count
            if (tick) begin
                if (ph == PH_IDLE) begin
                    busy_cnt = '0;
                end else if (busy_cnt < cur_limit) begin
                    busy_cnt = busy_cnt + 1'b1;
                end else begin
                    busy_cnt = '0;
                    ph = PH_IDLE;
                    drv = 1'b0;
                end
                if (tick_cnt < TICK_MAX)
                    tick_cnt = tick_cnt + 1'b1;
            end
            if (ph == PH_IDLE && rd_idx != wr_idx && !busy) begin
                drv = 1'b1;
                ph = PH_LEAD;
                tick_cnt = '0;
            end
            if (ph == PH_LEAD) begin
                if (cur_board == BOARD_IMMEDIATE && busy) begin
                    drv = 1'b0;
                    ph = PH_IDLE;
                end else if (tick_cnt >= cur_lead && !busy) begin
                    tick_cnt = '0;
                    ph = PH_SEND;
                end
            end
            if (ph == PH_SEND) begin
                if (rd_idx != wr_idx) begin
                    move_words(fint, level, wr_idx);
                    moved = 1'b1;
                end
                if (tick_cnt > cur_drain) begin
                    end_idx = wr_idx;
                    ph = PH_DRAIN;
                    tick_cnt = '0;
                end
            end
            // drain skips its transfer when send already had words pending this poll
            if (ph == PH_DRAIN) begin
                if (rd_idx != end_idx) begin
                    if (!moved)
                        move_words(fint, level, end_idx);
                end else begin
                    drv = 1'b0;
                    ph = PH_RELEASE;
                    tick_cnt = '0;
                end
            end
            if (ph == PH_RELEASE) begin
                if (cur_board == BOARD_IMMEDIATE ||
                    (cur_board == BOARD_ONE_TICK && tick_cnt >= 1)) begin
                    ph = PH_IDLE;
                    tick_cnt = '0;
                end
            end
        end
        foreach (burst_bytes[k]) begin
            item = '{KIND_BYTE, burst_bytes[k], drv, ph, 1'b0, 1'b0};
            uart_due.push_back(item);
        end
        item = '{KIND_STATUS, 8'd0, drv, ph, burst_clear, 1'b1};
        uart_due.push_back(item);
    endtask

    // offer one input word; valid stays up after acceptance until the next call decides
    task automatic offer_item(input logic op, input logic [WORD_W-1:0] word,
                              input logic tick, input logic fint,
                              input logic [LEVEL_W-1:0] level, input logic busy);
        int gap;
        gap = src_gaps ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_op         <= op;
        s_word       <= word;
        s_tick       <= tick;
        s_fifo_int   <= fint;
        s_fifo_level <= level;
        s_line_busy  <= busy;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        run_sequencer(op, word, tick, fint, level, busy);
    endtask

    // the unused poll fields of a push carry random values
    task automatic push_word(input logic [WORD_W-1:0] word);
        offer_item(OP_PUSH, word, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                   5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
    endtask

    task automatic poll_line(input logic tick, input logic fint,
                             input logic [LEVEL_W-1:0] level, input logic busy);
        offer_item(OP_POLL, 16'($urandom_range(0, 65535)), tick, fint, level, busy);
    endtask

    // stop offering and wait until every predicted word has come back
    task automatic wait_results;
        s_valid <= 1'b0;
        @(posedge aclk);
        while (uart_due.size() != 0) @(posedge aclk);
        repeat (6) @(posedge aclk);
    endtask

    // write all four registers while the block is quiet
    task automatic set_config(input logic [CODE_W-1:0] board, input logic [TICK_W-1:0] lead,
                              input logic [TICK_W-1:0] drain, input logic [BUSY_W-1:0] limit);
        logic [CFG_IDX_W-1:0] regs [4];
        logic [CFG_DAT_W-1:0] vals [4];
        regs = '{CFG_BOARD, CFG_LEAD, CFG_DRAIN, CFG_LIMIT};
        vals = '{{12'd0, board}, {12'd0, lead}, {12'd0, drain}, limit};
        wait_results();
        for (int k = 0; k < 4; k++) begin
            cfg_valid <= 1'b1;
            cfg_index <= regs[k];
            cfg_data  <= vals[k];
            @(posedge aclk);
            while (!cfg_ready) @(posedge aclk);
            case (regs[k])
                CFG_BOARD: cur_board = vals[k][CODE_W-1:0];
                CFG_LEAD:  cur_lead  = vals[k][TICK_W-1:0];
                CFG_DRAIN: cur_drain = vals[k][TICK_W-1:0];
                CFG_LIMIT: cur_limit = vals[k][BUSY_W-1:0];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // poll with ticks and free fifo until the ring empties and the line goes idle, at most 300 polls
    task automatic flush_ring;
        int guard;
        guard = 0;
        while ((rd_idx != wr_idx || ph != PH_IDLE) && guard < 300) begin
            poll_line(1'b1, 1'b1, 5'd0, 1'b0);
            guard++;
        end
    endtask

    // reset defaults: word extremes, busy line, fifo space cases, full cycle through phases
    task automatic test_directed;
        poll_line(1'b1, 1'b1, 5'd0, 1'b0);
        push_word(16'h0000);
        push_word(16'hFFFF);
        push_word(16'h00FF);
        push_word(16'hA55A);
        poll_line(1'b0, 1'b1, 5'd0, 1'b1);
        poll_line(1'b0, 1'b0, 5'd0, 1'b0);
        poll_line(1'b0, 1'b1, 5'd0, 1'b1);
        poll_line(1'b1, 1'b0, 5'd0, 1'b0);
        poll_line(1'b1, 1'b0, 5'd0, 1'b0);
        poll_line(1'b1, 1'b0, 5'd0, 1'b0);
        poll_line(1'b0, 1'b1, 5'd16, 1'b0);
        poll_line(1'b0, 1'b1, 5'd31, 1'b0);
        poll_line(1'b0, 1'b1, 5'd13, 1'b0);
        poll_line(1'b0, 1'b1, 5'd0, 1'b0);
        push_word(16'h1234);
        repeat (4) poll_line(1'b1, 1'b0, 5'd0, 1'b0);
        repeat (4) poll_line(1'b1, 1'b1, 5'd0, 1'b0);
        wait_results();
    endtask

    // busy counter forces idle while the fifo never signals space
    task automatic test_busy_timeout;
        set_config(BOARD_IMMEDIATE, 4'd1, 4'd3, 16'd3);
        push_word(16'($urandom_range(0, 65535)));
        push_word(16'($urandom_range(0, 65535)));
        push_word(16'($urandom_range(0, 65535)));
        repeat (8) poll_line(1'b1, 1'b0, 5'd0, 1'b0);
        flush_ring();
        wait_results();
    endtask

    // one-tick release, then a board code that holds release until the timeout
    task automatic test_release_timing;
        set_config(BOARD_ONE_TICK, 4'd0, 4'd0, 16'd1000);
        push_word(16'($urandom_range(0, 65535)));
        push_word(16'($urandom_range(0, 65535)));
        poll_line(1'b0, 1'b1, 5'd0, 1'b0);
        poll_line(1'b1, 1'b1, 5'd0, 1'b0);
        poll_line(1'b0, 1'b1, 5'd0, 1'b0);
        poll_line(1'b0, 1'b1, 5'd0, 1'b0);
        poll_line(1'b1, 1'b1, 5'd0, 1'b0);
        poll_line(1'b1, 1'b1, 5'd0, 1'b0);
        set_config(4'd9, 4'd0, 4'd0, 16'd4);
        push_word(16'($urandom_range(0, 65535)));
        push_word(16'($urandom_range(0, 65535)));
        poll_line(1'b0, 1'b1, 5'd0, 1'b0);
        repeat (9) poll_line(1'b1, 1'b1, 5'd0, 1'b0);
        wait_results();
    endtask

    // drain_ticks at its maximum: tick count saturates and only the timeout ends send
    task automatic test_tick_saturation;
        set_config(BOARD_IMMEDIATE, 4'd0, 4'd15, 16'd24);
        push_word(16'($urandom_range(0, 65535)));
        push_word(16'($urandom_range(0, 65535)));
        push_word(16'($urandom_range(0, 65535)));
        repeat (30) poll_line(1'b1, 1'($urandom_range(0, 1)), 5'd0, 1'b0);
        wait_results();
    endtask

    // result side held off while the sender keeps offering polls with an empty fifo
    task automatic test_backpressure;
        wait_results();
        src_gaps = 1'b0;
        sink_stalls = 1'b0;
        rx_hold = 300;
        repeat (12) push_word(16'($urandom_range(0, 65535)));
        repeat (8) poll_line(1'b1, 1'b1, 5'd0, 1'b0);
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        wait_results();
    endtask

    // mostly push bursts followed by poll runs, some raw noise, across several settings
    task automatic test_random;
        logic [CODE_W-1:0] boards [5];
        logic [TICK_W-1:0] leads [5];
        logic [TICK_W-1:0] drains [5];
        logic [BUSY_W-1:0] limits [5];
        logic [LEVEL_W-1:0] level;
        int sent;
        int nw;
        int np;
        boards = '{BOARD_ONE_TICK, 4'd0, 4'd15, BOARD_IMMEDIATE, BOARD_ONE_TICK};
        leads  = '{4'd1, 4'd0, 4'd15, 4'd3, 4'd2};
        drains = '{4'd2, 4'd0, 4'd15, 4'd5, 4'd1};
        limits = '{16'd40, 16'd0, 16'hFFFF, 16'd12, 16'd300};
        for (int p = 0; p < 5; p++) begin
            set_config(boards[p], leads[p], drains[p], limits[p]);
            sent = 0;
            while (sent < 6) begin
                src_gaps = ($urandom_range(0, 3) != 0);
                sink_stalls = ($urandom_range(0, 3) != 0);
                if ($urandom_range(0, 9) < 7) begin
                    nw = $urandom_range(1, 6);
                    np = $urandom_range(2, 8);
                    repeat (nw) push_word(16'($urandom_range(0, 65535)));
                    repeat (np) begin
                        level = ($urandom_range(0, 15) == 0) ? 5'($urandom_range(17, 31))
                                                             : 5'($urandom_range(0, 16));
                        poll_line($urandom_range(0, 9) < 7, $urandom_range(0, 4) != 0,
                                  level, $urandom_range(0, 9) == 0);
                    end
                    sent += nw + np;
                end else begin
                    offer_item(1'($urandom_range(0, 1)), 16'($urandom_range(0, 65535)),
                               1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                               5'($urandom_range(0, 31)), 1'($urandom_range(0, 1)));
                    sent++;
                end
            end
        end
        src_gaps = 1'b1;
        sink_stalls = 1'b1;
        wait_results();
    endtask

    // result side: random stall per word, plus the long hold-off when requested
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
            rx_wait = 0;
        end else if (rx_hold > 0) begin
            rx_hold = rx_hold - 1;
            m_ready <= 1'b0;
        end else if (m_valid && m_ready) begin
            rx_wait = sink_stalls ? $urandom_range(0, 3) : 0;
            m_ready <= (rx_wait == 0);
        end else if (rx_wait > 0) begin
            rx_wait = rx_wait - 1;
            m_ready <= (rx_wait == 0);
        end else begin
            m_ready <= 1'b1;
        end
    end

    // compare each accepted result word with the oldest prediction
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (uart_due.size() == 0) begin
                flag_mismatch("result with nothing due",
                              32'({m_kind, m_tx_byte, m_tx_enable, m_phase, m_int_clear,
                                   m_last}),
                              32'd0);
            end else begin
                want_now = uart_due.pop_front();
                if (m_kind !== want_now.kind)
                    flag_mismatch("kind", 32'(m_kind), 32'(want_now.kind));
                if (m_tx_byte !== want_now.tx_byte)
                    flag_mismatch("tx_byte", 32'(m_tx_byte), 32'(want_now.tx_byte));
                if (m_tx_enable !== want_now.tx_enable)
                    flag_mismatch("tx_enable", 32'(m_tx_enable), 32'(want_now.tx_enable));
                if (m_phase !== want_now.phase)
                    flag_mismatch("phase", 32'(m_phase), 32'(want_now.phase));
                if (m_int_clear !== want_now.int_clear)
                    flag_mismatch("int_clear", 32'(m_int_clear), 32'(want_now.int_clear));
                if (m_last !== want_now.last)
                    flag_mismatch("last", 32'(m_last), 32'(want_now.last));
            end
        end
    end

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_directed();
        test_busy_timeout();
        test_release_timing();
        test_tick_saturation();
        test_backpressure();
        test_random();

        // settle: wait until nothing is due, then keep watching for stray words
        s_valid <= 1'b0;
        @(posedge aclk);
        while (uart_due.size() != 0) @(posedge aclk);
        repeat (40) @(posedge aclk);

        if (errors == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
design/hdtx_pkg.sv
design/hdtx_ctrl.sv
design/hdtx_dp.sv
design/halfduplex_tx_sequencer_top.sv
dv/tb_top.sv
